// ===== hdl/rahfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rahfp_pkg
// Shared constants, types and helpers for the ascii hex frame parser.
// ----------------------------------------------------------------------------
package rahfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned IdW        = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned PosW       = 4;
  localparam int unsigned FrameBytes = 6;
  localparam int unsigned CheckBytes = 5;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 64;

  localparam logic [ByteW-1:0] StartByte = 8'h02;
  localparam logic [ByteW-1:0] EndByte   = 8'h03;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] AlphaBias = 8'h37;  // '7'
  localparam logic [ByteW-1:0] DigitBias = 8'h30;  // '0'

  // frame position codes
  localparam logic [PosW-1:0] PosFirst = 4'd0;
  localparam logic [PosW-1:0] PosEnd   = 4'd12;
  localparam logic [PosW-1:0] PosWait  = 4'd15;

  // frame status codes
  localparam logic [StatusW-1:0] StValid    = 2'd0;
  localparam logic [StatusW-1:0] StBadEnd   = 2'd1;
  localparam logic [StatusW-1:0] StBadCheck = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]   received_check;
    logic [ByteW-1:0]   computed_check;
    logic [StatusW-1:0] frame_status;
    logic [ByteW-1:0]   customer_byte;
    logic [IdW-1:0]     card_id;
  } result_t;

  // ascii hex character to nibble value, 8-bit wrap, no validity check
  function automatic logic [ByteW-1:0] hex_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    if (c > CharNine) begin
      v = c - AlphaBias;
    end else begin
      v = c - DigitBias;
    end
    return v;
  endfunction

endpackage

// ===== hdl/rahfp_assembler.sv =====
// ----------------------------------------------------------------------------
// rahfp_assembler
// Frame position tracking, nibble packing and end / checksum evaluation.
// ----------------------------------------------------------------------------
module rahfp_assembler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [rahfp_pkg::ByteW-1:0]       byte_i,
  output logic                              res_pending_o,
  output logic [rahfp_pkg::PosW-1:0]        pos_o,
  output rahfp_pkg::result_t                res_o
);

  logic [rahfp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [rahfp_pkg::ByteW-1:0] bytes_q [rahfp_pkg::FrameBytes];
  logic [rahfp_pkg::ByteW-1:0] hex_v;
  logic [rahfp_pkg::IdxW-1:0]  idx;
  logic                        in_frame;
  logic [rahfp_pkg::ByteW-1:0] chk;

  assign in_frame = (pos_q < rahfp_pkg::PosEnd);
  assign idx      = pos_q[rahfp_pkg::PosW-1:1];
  assign hex_v    = rahfp_pkg::hex_value(byte_i);

  always_comb begin
    pos_d = pos_q;
    if (in_frame) begin
      pos_d = pos_q + 4'd1;
    end else if (pos_q == rahfp_pkg::PosEnd) begin
      pos_d = rahfp_pkg::PosWait;
    end else if (byte_i == rahfp_pkg::StartByte) begin
      pos_d = rahfp_pkg::PosFirst;
    end else begin
      pos_d = rahfp_pkg::PosWait;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= rahfp_pkg::PosWait;
    end else if (step_i) begin
      pos_q <= pos_d;
    end
  end

  // even character writes the high nibble, odd one adds the low part
  always_ff @(posedge clk_i) begin
    if (step_i && in_frame) begin
      if (!pos_q[0]) begin
        bytes_q[idx] <= {hex_v[3:0], 4'h0};
      end else begin
        bytes_q[idx] <= bytes_q[idx] + hex_v;
      end
    end
  end

  always_comb begin
    chk = bytes_q[0];
    for (int i = 1; i < rahfp_pkg::CheckBytes; i++) begin
      chk = chk ^ bytes_q[i];
    end
  end

  always_comb begin
    res_o.card_id        = {bytes_q[1], bytes_q[2], bytes_q[3], bytes_q[4]};
    res_o.customer_byte  = bytes_q[0];
    res_o.computed_check = chk;
    res_o.received_check = bytes_q[5];
    if (byte_i != rahfp_pkg::EndByte) begin
      res_o.frame_status = rahfp_pkg::StBadEnd;
    end else if (chk != bytes_q[5]) begin
      res_o.frame_status = rahfp_pkg::StBadCheck;
    end else begin
      res_o.frame_status = rahfp_pkg::StValid;
    end
  end

  assign res_pending_o = (pos_q == rahfp_pkg::PosEnd);
  assign pos_o         = pos_q;

endmodule

// ===== hdl/rahfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// rahfp_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module rahfp_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  rahfp_pkg::result_t                 res_i,
  output logic                               can_load_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rahfp_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic               valid_q;
  rahfp_pkg::result_t res_q;

  assign can_load_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(rahfp_pkg::OutDataW - $bits(rahfp_pkg::result_t)){1'b0}}, res_q};

endmodule

// ===== hdl/rfid_ascii_hex_frame_parser.sv =====
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_parser
// Parses start / 12 ascii hex chars / end frames and checks the xor byte.
//
//   channel  dir  tdata (low bit up)                          per word
//   s_axis   in   rx_byte[7:0]                                one byte
//   m_axis   out  card_id, customer_byte, frame_status,       one frame result
//                 computed_check, received_check, zero pad
//
// one word per cycle unless a frame end waits on a full result register: input
// register, one pass of nibble / xor logic, result register.
// reset clears the position to waiting for start and empties both registers.
// a stalled m_axis holds its result while words that end no frame keep flowing;
// a word that completes a frame waits in the input register until the result
// register frees, and s_axis_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module rfid_ascii_hex_frame_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rahfp_pkg::InDataW-1:0]      s_axis_tdata,   // rx_byte[7:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // card_id[31:0], customer_byte[39:32], frame_status[41:40],
  // computed_check[49:42], received_check[57:50], zero[63:58]
  output logic [rahfp_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                        in_valid_q;
  logic [rahfp_pkg::ByteW-1:0] in_byte_q;
  logic                        advance;
  logic                        res_pending;
  logic                        can_load;
  logic [rahfp_pkg::PosW-1:0]  pos;
  rahfp_pkg::result_t          res;

  // a word that ends no frame moves on even when the result register is full
  assign advance       = in_valid_q && (!res_pending || can_load);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata[rahfp_pkg::ByteW-1:0];
    end
  end

  rahfp_assembler u_assembler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .res_pending_o (res_pending),
    .pos_o         (pos),
    .res_o         (res)
  );

  rahfp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && res_pending),
    .res_i         (res),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos <= rahfp_pkg::PosEnd) || (pos == rahfp_pkg::PosWait))
    else $error("frame position left the legal range");

  a_end_returns_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_pending) |=> (pos == rahfp_pkg::PosWait))
    else $error("frame end did not return to waiting for start");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input word was lost or changed");

  a_result_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_pending) |=> m_axis_tvalid)
    else $error("finished frame did not reach the output");
`endif

endmodule
